// ===== rtl/tensor_interp_grid_potential_unit_macros.svh =====
// Assertion macros for the grid potential unit.
`ifndef TENSOR_INTERP_GRID_POTENTIAL_UNIT_MACROS_SVH
`define TENSOR_INTERP_GRID_POTENTIAL_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define TIGP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tigp assertion failed");

`define TIGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tigp assertion failed");

`else

`define TIGP_ASSERT(label, prop)

`define TIGP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/tigp_pkg.sv =====
package tigp_pkg;

  localparam int MAX_POINTS_PER_AXIS = 8;
  localparam int MAX_LEAF_SPAN       = 64;
  localparam int MAX_GRID_DIM        = 1024;

  localparam int CHARGE_DEPTH = MAX_POINTS_PER_AXIS * MAX_POINTS_PER_AXIS * MAX_POINTS_PER_AXIS;
  localparam int COEFF_DEPTH  = MAX_POINTS_PER_AXIS * MAX_LEAF_SPAN;
  localparam int CH_AW = (CHARGE_DEPTH > 1) ? $clog2(CHARGE_DEPTH) : 1;
  localparam int CO_AW = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;

  localparam int MODE_W     = 3;
  localparam int ADDR_W     = 9;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 10;
  localparam int ORDER_W    = 3;
  localparam int GS_W       = 11;
  localparam int FLAT_W     = 30;
  localparam int CONTRIB_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int P_W  = $clog2(MAX_POINTS_PER_AXIS + 1);
  localparam int BX_W = IDX_W + P_W;

  localparam logic [MODE_W-1:0] MODE_LOAD_Q = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_X = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_Y = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_Z = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EVAL   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZSIZE = 2'd2;

  typedef struct packed {
    logic [P_W-1:0]  p;
    logic [GS_W-1:0] ys;
    logic [GS_W-1:0] zs;
  } cfg_t;

  typedef struct packed {
    logic            accept;
    logic            init;
    logic            issue;
    logic            wrap3;
    logic            wrap2;
    logic            load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

// ===== rtl/tigp_ram.sv =====
module tigp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tigp_ctrl.sv =====
module tigp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tigp_pkg::MODE_W-1:0]   in_mode,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  tigp_pkg::cfg_t                cfg,
  input  tigp_pkg::stat_t               stat,
  output tigp_pkg::cmd_t                cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                         state_r;
  logic                           out_valid_r;
  logic [tigp_pkg::P_W-1:0]       k1_r;
  logic [tigp_pkg::P_W-1:0]       k2_r;
  logic [tigp_pkg::P_W-1:0]       k3_r;
  logic [tigp_pkg::P_W-1:0]       pm1;
  logic                           last;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign pm1       = cfg.p - tigp_pkg::P_W'(1);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && !in_stall;
    cmd.init     = (state_r == S_LOAD);
    cmd.issue    = (state_r == S_RUN);
    cmd.wrap3    = (state_r == S_RUN) && (k3_r == pm1);
    cmd.wrap2    = cmd.wrap3 && (k2_r == pm1);
    cmd.load_out = (state_r == S_DRAIN) && !stat.pipe_busy && (!out_valid_r || !out_stall);
    last         = cmd.wrap2 && (k1_r == pm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k1_r        <= '0;
      k2_r        <= '0;
      k3_r        <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.accept && (in_mode == tigp_pkg::MODE_EVAL)) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          k1_r    <= '0;
          k2_r    <= '0;
          k3_r    <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          k3_r <= cmd.wrap3 ? '0 : k3_r + tigp_pkg::P_W'(1);
          if (cmd.wrap3) begin
            k2_r <= cmd.wrap2 ? '0 : k2_r + tigp_pkg::P_W'(1);
          end
          if (cmd.wrap2) begin
            k1_r <= k1_r + tigp_pkg::P_W'(1);
          end
          if (last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (cmd.load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tigp_dp.sv =====
module tigp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tigp_pkg::cmd_t                       cmd,
  input  tigp_pkg::cfg_t                       cfg,
  input  logic [tigp_pkg::MODE_W-1:0]          in_mode,
  input  logic [tigp_pkg::ADDR_W-1:0]          in_address,
  input  logic signed [tigp_pkg::VALUE_W-1:0]  in_value,
  input  logic [tigp_pkg::IDX_W-1:0]           in_x_index,
  input  logic [tigp_pkg::IDX_W-1:0]           in_y_index,
  input  logic [tigp_pkg::IDX_W-1:0]           in_z_index,
  input  logic [tigp_pkg::IDX_W-1:0]           in_x_low,
  input  logic [tigp_pkg::IDX_W-1:0]           in_y_low,
  input  logic [tigp_pkg::IDX_W-1:0]           in_z_low,
  output tigp_pkg::stat_t                      stat,
  output logic [tigp_pkg::FLAT_W-1:0]          out_flat_index,
  output logic signed [tigp_pkg::CONTRIB_W-1:0] out_contribution
);

  localparam int VW      = tigp_pkg::VALUE_W;
  localparam int P1_W    = 2 * VW;
  localparam int WXY_W   = VW + 2;
  localparam int P2_W    = WXY_W + VW;
  localparam int W_W     = VW + 1;
  localparam int P3_W    = W_W + VW;
  localparam int TERM_W  = VW + 5;
  localparam int ACC_W   = TERM_W + tigp_pkg::CH_AW + 1;
  localparam int EXT_W   = (ACC_W > tigp_pkg::CONTRIB_W) ? ACC_W : tigp_pkg::CONTRIB_W;
  localparam int T1_W    = tigp_pkg::IDX_W + tigp_pkg::GS_W;
  localparam int PIPE_D  = 7;
  localparam int CW      = tigp_pkg::CONTRIB_W;
  localparam int BX_W    = tigp_pkg::BX_W;
  localparam int CO_AW   = tigp_pkg::CO_AW;
  localparam int CH_AW   = tigp_pkg::CH_AW;

  localparam logic signed [P1_W-1:0] HALF1 = P1_W'(1) << 29;
  localparam logic signed [P2_W-1:0] HALF2 = P2_W'(1) << 31;
  localparam logic signed [P3_W-1:0] HALF3 = P3_W'(1) << 27;

  function automatic logic [CO_AW-1:0] inc_addr(input logic [CO_AW-1:0] a);
    if (a == CO_AW'(tigp_pkg::COEFF_DEPTH - 1)) begin
      return '0;
    end
    return a + CO_AW'(1);
  endfunction

  logic                       ld_q;
  logic                       ld_x;
  logic                       ld_y;
  logic                       ld_z;
  logic                       ld_eval;
  logic [CH_AW-1:0]           q_waddr;
  logic [CO_AW-1:0]           c_waddr;
  logic [tigp_pkg::IDX_W-1:0] off_x;
  logic [tigp_pkg::IDX_W-1:0] off_y;
  logic [tigp_pkg::IDX_W-1:0] off_z;

  logic [CO_AW-1:0]           rx_r;
  logic [CO_AW-1:0]           ry_r;
  logic [CO_AW-1:0]           rz_r;
  logic [CO_AW-1:0]           ax_r;
  logic [CO_AW-1:0]           ay_r;
  logic [CO_AW-1:0]           az_r;
  logic [CH_AW-1:0]           n_r;
  logic [T1_W-1:0]            t1_r;
  logic [T1_W:0]              yz_r;
  logic [tigp_pkg::FLAT_W-1:0] idx_r;

  logic [VW-1:0]              q_rdata;
  logic [VW-1:0]              x_rdata;
  logic [VW-1:0]              y_rdata;
  logic [VW-1:0]              z_rdata;
  logic signed [VW-1:0]       cx;
  logic signed [VW-1:0]       cy;
  logic signed [VW-1:0]       cz;
  logic signed [VW-1:0]       qv;

  logic [PIPE_D-1:0]          vld_r;
  logic signed [P1_W-1:0]     p1_r;
  logic signed [VW-1:0]       cz2_r;
  logic signed [VW-1:0]       q2_r;
  logic signed [WXY_W-1:0]    wxy_r;
  logic signed [VW-1:0]       cz3_r;
  logic signed [VW-1:0]       q3_r;
  logic signed [P2_W-1:0]     p2_r;
  logic signed [VW-1:0]       q4_r;
  logic signed [W_W-1:0]      w_r;
  logic signed [VW-1:0]       q5_r;
  logic signed [P3_W-1:0]     p3_r;
  logic signed [TERM_W-1:0]   term_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic signed [P1_W-1:0]     sum1;
  logic signed [P2_W-1:0]     sum2;
  logic signed [P3_W-1:0]     sum3;
  logic signed [EXT_W-1:0]    acc_ext;
  logic [EXT_W-CW:0]          acc_hi;
  logic signed [CW-1:0]       sat_val;

  assign ld_q    = cmd.accept && (in_mode == tigp_pkg::MODE_LOAD_Q);
  assign ld_x    = cmd.accept && (in_mode == tigp_pkg::MODE_LOAD_X);
  assign ld_y    = cmd.accept && (in_mode == tigp_pkg::MODE_LOAD_Y);
  assign ld_z    = cmd.accept && (in_mode == tigp_pkg::MODE_LOAD_Z);
  assign ld_eval = cmd.accept && (in_mode == tigp_pkg::MODE_EVAL);
  assign q_waddr = CH_AW'(in_address % tigp_pkg::CHARGE_DEPTH);
  assign c_waddr = CO_AW'(in_address % tigp_pkg::COEFF_DEPTH);
  assign off_x   = in_x_index - in_x_low;
  assign off_y   = in_y_index - in_y_low;
  assign off_z   = in_z_index - in_z_low;

  tigp_ram #(.WIDTH(VW), .DEPTH(tigp_pkg::CHARGE_DEPTH)) u_q_ram (
    .clk     (clk),
    .wr_en   (ld_q),
    .wr_addr (q_waddr),
    .wr_data (in_value),
    .rd_addr (n_r),
    .rd_data (q_rdata)
  );

  tigp_ram #(.WIDTH(VW), .DEPTH(tigp_pkg::COEFF_DEPTH)) u_x_ram (
    .clk     (clk),
    .wr_en   (ld_x),
    .wr_addr (c_waddr),
    .wr_data (in_value),
    .rd_addr (ax_r),
    .rd_data (x_rdata)
  );

  tigp_ram #(.WIDTH(VW), .DEPTH(tigp_pkg::COEFF_DEPTH)) u_y_ram (
    .clk     (clk),
    .wr_en   (ld_y),
    .wr_addr (c_waddr),
    .wr_data (in_value),
    .rd_addr (ay_r),
    .rd_data (y_rdata)
  );

  tigp_ram #(.WIDTH(VW), .DEPTH(tigp_pkg::COEFF_DEPTH)) u_z_ram (
    .clk     (clk),
    .wr_en   (ld_z),
    .wr_addr (c_waddr),
    .wr_data (in_value),
    .rd_addr (az_r),
    .rd_data (z_rdata)
  );

  assign cx = x_rdata;
  assign cy = y_rdata;
  assign cz = z_rdata;
  assign qv = q_rdata;

  // row bases, read addresses and flat index
  always_ff @(posedge clk) begin
    if (ld_eval) begin
      rx_r <= CO_AW'((BX_W'(off_x) * BX_W'(cfg.p)) % tigp_pkg::COEFF_DEPTH);
      ry_r <= CO_AW'((BX_W'(off_y) * BX_W'(cfg.p)) % tigp_pkg::COEFF_DEPTH);
      rz_r <= CO_AW'((BX_W'(off_z) * BX_W'(cfg.p)) % tigp_pkg::COEFF_DEPTH);
      t1_r <= T1_W'(in_x_index) * T1_W'(cfg.ys);
      yz_r <= (T1_W + 1)'(in_y_index) * (T1_W + 1)'(cfg.zs) + (T1_W + 1)'(in_z_index);
    end
    if (cmd.init) begin
      ax_r  <= rx_r;
      ay_r  <= ry_r;
      az_r  <= rz_r;
      n_r   <= '0;
      idx_r <= tigp_pkg::FLAT_W'(32'(t1_r) * 32'(cfg.zs) + 32'(yz_r));
    end else if (cmd.issue) begin
      n_r  <= n_r + CH_AW'(1);
      az_r <= cmd.wrap3 ? rz_r : inc_addr(az_r);
      if (cmd.wrap3) begin
        ay_r <= cmd.wrap2 ? ry_r : inc_addr(ay_r);
      end
      if (cmd.wrap2) begin
        ax_r <= inc_addr(ax_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_D-2:0], cmd.issue};
    end
  end

  assign stat.pipe_busy = |vld_r;

  always_comb begin
    sum1 = p1_r + HALF1;
    sum2 = p2_r + HALF2;
    sum3 = p3_r + HALF3;
  end

  always_ff @(posedge clk) begin
    p1_r   <= cx * cy;
    cz2_r  <= cz;
    q2_r   <= qv;
    wxy_r  <= sum1[30 +: WXY_W];
    cz3_r  <= cz2_r;
    q3_r   <= q2_r;
    p2_r   <= wxy_r * cz3_r;
    q4_r   <= q3_r;
    w_r    <= sum2[32 +: W_W];
    q5_r   <= q4_r;
    p3_r   <= w_r * q5_r;
    term_r <= sum3[28 +: TERM_W];
    if (cmd.init) begin
      acc_r <= '0;
    end else if (vld_r[PIPE_D-1]) begin
      acc_r <= acc_r + ACC_W'(term_r);
    end
  end

  always_comb begin
    acc_ext = EXT_W'(acc_r);
    acc_hi  = acc_ext[EXT_W-1:CW-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_val = acc_ext[CW-1:0];
    end else if (acc_ext[EXT_W-1]) begin
      sat_val = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(CW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_flat_index   <= idx_r;
      out_contribution <= sat_val;
    end
  end

endmodule

// ===== rtl/tensor_interp_grid_potential_unit.sv =====
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    mode, address, value, x/y/z_index, x/y/z_low
// out      out  out_valid / out_stall  flat_index, contribution
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load transaction writes its store when accepted. An evaluate runs through the accepting
// cycle, a setup state, then one point per cycle through the single
// multiply-accumulate chain, and a drain of its seven stages.
// Reset is synchronous and returns control and configuration to defaults; the stores are not cleared.
// in_stall stays high during an evaluate; a finished result waits in the output register
// while new transactions are taken, and the next result holds until out_stall drops.
`include "tensor_interp_grid_potential_unit_macros.svh"

module tensor_interp_grid_potential_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [tigp_pkg::MODE_W-1:0]            in_mode,
  input  logic [tigp_pkg::ADDR_W-1:0]            in_address,
  input  logic signed [tigp_pkg::VALUE_W-1:0]    in_value,
  input  logic [tigp_pkg::IDX_W-1:0]             in_x_index,
  input  logic [tigp_pkg::IDX_W-1:0]             in_y_index,
  input  logic [tigp_pkg::IDX_W-1:0]             in_z_index,
  input  logic [tigp_pkg::IDX_W-1:0]             in_x_low,
  input  logic [tigp_pkg::IDX_W-1:0]             in_y_low,
  input  logic [tigp_pkg::IDX_W-1:0]             in_z_low,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tigp_pkg::FLAT_W-1:0]            out_flat_index,
  output logic signed [tigp_pkg::CONTRIB_W-1:0]  out_contribution,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tigp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tigp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [tigp_pkg::ORDER_W-1:0] order_r;
  logic [tigp_pkg::GS_W-1:0]    ysize_r;
  logic [tigp_pkg::GS_W-1:0]    zsize_r;
  logic [tigp_pkg::ORDER_W:0]   p_raw;
  tigp_pkg::cfg_t               cfg;
  tigp_pkg::cmd_t               cmd;
  tigp_pkg::stat_t              stat;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= tigp_pkg::ORDER_W'(7);
      ysize_r <= tigp_pkg::GS_W'(64);
      zsize_r <= tigp_pkg::GS_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tigp_pkg::CFG_ORDER: order_r <= cfg_data[tigp_pkg::ORDER_W-1:0];
        tigp_pkg::CFG_YSIZE: ysize_r <= cfg_data[tigp_pkg::GS_W-1:0];
        tigp_pkg::CFG_ZSIZE: zsize_r <= cfg_data[tigp_pkg::GS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    p_raw  = {1'b0, order_r} + (tigp_pkg::ORDER_W + 1)'(1);
    cfg.p  = (int'(p_raw) > tigp_pkg::MAX_POINTS_PER_AXIS) ?
             tigp_pkg::P_W'(tigp_pkg::MAX_POINTS_PER_AXIS) : tigp_pkg::P_W'(p_raw);
    cfg.ys = (int'(ysize_r) > tigp_pkg::MAX_GRID_DIM) ?
             tigp_pkg::GS_W'(tigp_pkg::MAX_GRID_DIM) : ysize_r;
    cfg.zs = (int'(zsize_r) > tigp_pkg::MAX_GRID_DIM) ?
             tigp_pkg::GS_W'(tigp_pkg::MAX_GRID_DIM) : zsize_r;
  end

  tigp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd)
  );

  tigp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_value         (in_value),
    .in_x_index       (in_x_index),
    .in_y_index       (in_y_index),
    .in_z_index       (in_z_index),
    .in_x_low         (in_x_low),
    .in_y_low         (in_y_low),
    .in_z_low         (in_z_low),
    .stat             (stat),
    .out_flat_index   (out_flat_index),
    .out_contribution (out_contribution)
  );

  `TIGP_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid)
  `TIGP_ASSERT(a_load_when_free, !cmd.load_out || !out_valid || !out_stall)
  `TIGP_ASSERT(a_issue_while_busy, !cmd.issue || in_stall)
  `TIGP_ASSERT(a_accept_pipe_empty, !cmd.accept || !stat.pipe_busy)

endmodule

// ===== bench/tb_tensor_interp_grid_potential_unit.sv =====
`timescale 1ns / 100ps

module tb_tensor_interp_grid_potential_unit;
  import tigp_pkg::*;

  localparam int QUIET_CYCLES   = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRESSURE_HOLD  = 3000;

  localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  localparam longint SAT_HI = (longint'(1) <<< 47) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 47);

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [ADDR_W-1:0]         address;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          x_index;
    logic [IDX_W-1:0]          y_index;
    logic [IDX_W-1:0]          z_index;
    logic [IDX_W-1:0]          x_low;
    logic [IDX_W-1:0]          y_low;
    logic [IDX_W-1:0]          z_low;
  } grid_item_t;

  typedef struct packed {
    logic [FLAT_W-1:0]           flat_index;
    logic signed [CONTRIB_W-1:0] contribution;
  } grid_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [MODE_W-1:0]            in_mode = '0;
  logic [ADDR_W-1:0]            in_address = '0;
  logic signed [VALUE_W-1:0]    in_value = '0;
  logic [IDX_W-1:0]             in_x_index = '0;
  logic [IDX_W-1:0]             in_y_index = '0;
  logic [IDX_W-1:0]             in_z_index = '0;
  logic [IDX_W-1:0]             in_x_low = '0;
  logic [IDX_W-1:0]             in_y_low = '0;
  logic [IDX_W-1:0]             in_z_low = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [FLAT_W-1:0]            out_flat_index;
  logic signed [CONTRIB_W-1:0]  out_contribution;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  tensor_interp_grid_potential_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_value         (in_value),
    .in_x_index       (in_x_index),
    .in_y_index       (in_y_index),
    .in_z_index       (in_z_index),
    .in_x_low         (in_x_low),
    .in_y_low         (in_y_low),
    .in_z_low         (in_z_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flat_index   (out_flat_index),
    .out_contribution (out_contribution),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Predictor state
  logic signed [VALUE_W-1:0] charge_mem [CHARGE_DEPTH];
  logic signed [VALUE_W-1:0] x_coeff_mem [COEFF_DEPTH];
  logic signed [VALUE_W-1:0] y_coeff_mem [COEFF_DEPTH];
  logic signed [VALUE_W-1:0] z_coeff_mem [COEFF_DEPTH];
  logic [ORDER_W-1:0]        model_order = 3'd7;
  logic [GS_W-1:0]           model_ysize = 11'd64;
  logic [GS_W-1:0]           model_zsize = 11'd64;

  grid_item_t   item_backlog [$];
  grid_result_t contrib_queue [$];
  grid_item_t   cur_item;
  grid_result_t expected_r;

  bit entry_loaded [4][CHARGE_DEPTH];
  int gen_p = 8;
  int phase_items = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_drop(longint v, int n);
    longint u;
    u = v + (longint'(1) <<< (n - 1));
    return u >>> n;
  endfunction

  function automatic grid_result_t interpolate_point(grid_item_t it);
    grid_result_t res;
    logic [IDX_W-1:0] ox, oy, oz;
    int p, bx, by, bz, k1, k2, k3;
    longint cx, cy, cz, wxy, w, q, acc, ys, zs, flat;
    p = int'(model_order) + 1;
    if (p > MAX_POINTS_PER_AXIS) p = MAX_POINTS_PER_AXIS;
    ox = it.x_index - it.x_low;
    oy = it.y_index - it.y_low;
    oz = it.z_index - it.z_low;
    bx = int'(ox) * p;
    by = int'(oy) * p;
    bz = int'(oz) * p;
    acc = 0;
    for (k1 = 0; k1 < p; k1++) begin
      cx = longint'(x_coeff_mem[(bx + k1) % COEFF_DEPTH]);
      for (k2 = 0; k2 < p; k2++) begin
        cy = longint'(y_coeff_mem[(by + k2) % COEFF_DEPTH]);
        wxy = round_drop(cx * cy, 30);
        for (k3 = 0; k3 < p; k3++) begin
          cz = longint'(z_coeff_mem[(bz + k3) % COEFF_DEPTH]);
          w = round_drop(wxy * cz, 32);
          q = longint'(charge_mem[((k1 * p + k2) * p + k3) % CHARGE_DEPTH]);
          acc += round_drop(w * q, 28);
        end
      end
    end
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    ys = (model_ysize > MAX_GRID_DIM) ? longint'(MAX_GRID_DIM) : longint'(model_ysize);
    zs = (model_zsize > MAX_GRID_DIM) ? longint'(MAX_GRID_DIM) : longint'(model_zsize);
    flat = longint'(it.x_index) * ys * zs + longint'(it.y_index) * zs + longint'(it.z_index);
    res.flat_index = flat[FLAT_W-1:0];
    res.contribution = acc[CONTRIB_W-1:0];
    return res;
  endfunction

  task automatic absorb_item(input grid_item_t it);
    case (it.mode)
      MODE_LOAD_Q: charge_mem[it.address] = it.value;
      MODE_LOAD_X: x_coeff_mem[it.address] = it.value;
      MODE_LOAD_Y: y_coeff_mem[it.address] = it.value;
      MODE_LOAD_Z: z_coeff_mem[it.address] = it.value;
      MODE_EVAL:   contrib_queue.push_back(interpolate_point(it));
      default: ;
    endcase
  endtask

  // Stimulus generation
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3, 4, 5: v = {{3{v[31]}}, v[28:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic grid_item_t rand_item();
    grid_item_t it;
    it.mode = MODE_W'($urandom_range(0, 7));
    it.address = ADDR_W'($urandom);
    it.value = pick_value();
    it.x_index = IDX_W'($urandom);
    it.y_index = IDX_W'($urandom);
    it.z_index = IDX_W'($urandom);
    it.x_low = IDX_W'($urandom);
    it.y_low = IDX_W'($urandom);
    it.z_low = IDX_W'($urandom);
    return it;
  endfunction

  task automatic push_item(input grid_item_t it, input bit counts);
    item_backlog.push_back(it);
    items_queued++;
    if (counts) phase_items++;
    if (it.mode < MODE_EVAL) entry_loaded[it.mode][it.address] = 1'b1;
  endtask

  task automatic load_entry(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                            input logic [VALUE_W-1:0] val);
    grid_item_t it;
    it = rand_item();
    it.mode = mode;
    it.address = addr;
    it.value = val;
    push_item(it, 1'b1);
  endtask

  task automatic cover_charges(input bit reload);
    int i;
    for (i = 0; i < gen_p * gen_p * gen_p; i++) begin
      if (reload || !entry_loaded[MODE_LOAD_Q][i])
        load_entry(MODE_LOAD_Q, ADDR_W'(i), pick_value());
    end
  endtask

  task automatic cover_row(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] offset,
                           input bit reload);
    int k, a;
    for (k = 0; k < gen_p; k++) begin
      a = (int'(offset) * gen_p + k) % COEFF_DEPTH;
      if (reload || !entry_loaded[mode][a]) load_entry(mode, ADDR_W'(a), pick_value());
    end
  endtask

  // Load whatever the evaluate would read that was never written, then the evaluate.
  task automatic queue_eval(input logic [IDX_W-1:0] xi, yi, zi, xl, yl, zl);
    grid_item_t it;
    cover_charges(1'b0);
    cover_row(MODE_LOAD_X, xi - xl, 1'b0);
    cover_row(MODE_LOAD_Y, yi - yl, 1'b0);
    cover_row(MODE_LOAD_Z, zi - zl, 1'b0);
    it = rand_item();
    it.mode = MODE_EVAL;
    it.x_index = xi;
    it.y_index = yi;
    it.z_index = zi;
    it.x_low = xl;
    it.y_low = yl;
    it.z_low = zl;
    push_item(it, 1'b1);
  endtask

  function automatic logic [IDX_W-1:0] near_offset();
    if ($urandom_range(0, 9) < 8) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom);
  endfunction

  task automatic directed_items();
    grid_item_t it;
    int m;
    load_entry(MODE_LOAD_Q, 0, 32'h7fff_ffff);
    load_entry(MODE_LOAD_X, 0, 32'h4000_0000);
    load_entry(MODE_LOAD_Y, 0, 32'h4000_0000);
    load_entry(MODE_LOAD_Z, 0, 32'h4000_0000);
    queue_eval(0, 0, 0, 0, 0, 0);
    queue_eval(1023, 1023, 1023, 1023, 1023, 1023);
    load_entry(MODE_LOAD_X, 511, 32'h8000_0000);
    load_entry(MODE_LOAD_Y, 511, 32'h8000_0000);
    load_entry(MODE_LOAD_Z, 511, 32'h8000_0000);
    load_entry(MODE_LOAD_Q, 0, 32'h8000_0000);
    // targets below the leaf: offsets wrap to 1023, rows wrap past the store
    queue_eval(0, 0, 0, 1, 1, 1);
    load_entry(MODE_LOAD_Q, 511, 32'hffff_ffff);
    load_entry(MODE_LOAD_Z, 0, 32'h0);
    queue_eval(1023, 0, 1023, 0, 0, 0);
    for (m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      it = rand_item();
      it.mode = MODE_W'(m);
      push_item(it, 1'b0);
    end
    queue_eval(700, 5, 1000, 100, 900, 400);
  endtask

  task automatic random_traffic(input int quota);
    grid_item_t it;
    logic [IDX_W-1:0] xl, yl, zl, ox, oy, oz;
    int r;
    xl = IDX_W'($urandom);
    yl = IDX_W'($urandom);
    zl = IDX_W'($urandom);
    while (phase_items < quota) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        it = rand_item();
        it.mode = MODE_W'($urandom_range(MODE_LOAD_Q, MODE_LOAD_Z));
        push_item(it, 1'b1);
      end else if (r < 8) begin
        it = rand_item();
        it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        push_item(it, 1'b0);
      end else if (r < 14) begin
        if (gen_p <= 5) cover_charges(1'b1);
        else repeat (8) load_entry(MODE_LOAD_Q, ADDR_W'($urandom_range(0, gen_p ** 3 - 1)),
                                   pick_value());
      end else if (r < 24) begin
        xl = IDX_W'($urandom);
        yl = IDX_W'($urandom);
        zl = IDX_W'($urandom);
      end else if (r < 34) begin
        cover_row(MODE_LOAD_X, near_offset(), 1'b1);
        cover_row(MODE_LOAD_Y, near_offset(), 1'b1);
        cover_row(MODE_LOAD_Z, near_offset(), 1'b1);
      end else begin
        ox = near_offset();
        oy = near_offset();
        oz = near_offset();
        queue_eval(xl + ox, yl + oy, zl + oz, xl, yl, zl);
      end
    end
  endtask

  // Configuration writes; caller lowers cfg_valid after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ORDER: model_order = data[ORDER_W-1:0];
      CFG_YSIZE: model_ysize = data;
      CFG_ZSIZE: model_zsize = data;
      default: ;
    endcase
  endtask

  task automatic start_phase(input logic [ORDER_W-1:0] order, input logic [GS_W-1:0] ys, zs,
                             input int s_pct, r_pct);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_write(CFG_ORDER, {junk, order});
    cfg_write(CFG_YSIZE, ys);
    cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write(CFG_ZSIZE, zs);
    cfg_valid <= 1'b0;
    gen_p = int'(model_order) + 1;
    send_pct = s_pct;
    recv_pct = r_pct;
    phase_items = 0;
  endtask

  task automatic drain();
    while (items_accepted != items_queued || contrib_queue.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    start_phase(3'd0, 11'd1024, 11'd1024, 0, 0);
    directed_items();
    drain();
    start_phase(3'd1, 11'd64, 11'd64, 0, 0);
    random_traffic(150);
    drain();
    start_phase(3'd3, 11'd0, 11'd2047, 75, 0);
    random_traffic(150);
    drain();
    start_phase(3'd2, 11'd2047, 11'd1, 0, 75);
    random_traffic(150);
    drain();
    start_phase(3'd7, 11'd1, 11'd1024, 26, 26);
    random_traffic(560);
    drain();
    start_phase(3'd1, GS_W'($urandom_range(1, 1024)), GS_W'($urandom_range(1, 1024)), 0, 0);
    long_hold_armed = 1'b1;
    random_traffic(80);
    drain();
    start_phase(3'd4, GS_W'($urandom_range(1, 1024)), GS_W'($urandom_range(1, 1024)), 26, 75);
    random_traffic(60);
    drain();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Input driver: hold a stalled transaction, advance on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_item(cur_item);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          cur_item = item_backlog.pop_front();
          in_mode <= cur_item.mode;
          in_address <= cur_item.address;
          in_value <= cur_item.value;
          in_x_index <= cur_item.x_index;
          in_y_index <= cur_item.y_index;
          in_z_index <= cur_item.z_index;
          in_x_low <= cur_item.x_low;
          in_y_low <= cur_item.y_low;
          in_z_low <= cur_item.z_low;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (contrib_queue.size() == 0) begin
        $display("%0t: unexpected result, actual flat_index %0d contribution %0d",
                 $time, out_flat_index, out_contribution);
        fail_count++;
      end else begin
        expected_r = contrib_queue.pop_front();
        if (out_flat_index !== expected_r.flat_index) begin
          $display("%0t: flat_index expected %0d actual %0d",
                   $time, expected_r.flat_index, out_flat_index);
          fail_count++;
        end
        if (out_contribution !== expected_r.contribution) begin
          $display("%0t: contribution expected %0d actual %0d",
                   $time, expected_r.contribution, out_contribution);
          fail_count++;
        end
      end
    end
    if (long_hold_armed && !long_hold_done) begin
      hold_left = PRESSURE_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
